FILE: rtl/gnhm_pkg.sv
// ----------------------------------------------------------------------------
// gnhm_pkg
// Shared types, codes and tables of the gated nearest hit matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gnhm_pkg;

    localparam int MAX_HITS_DEF = 64;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    localparam logic [1:0] CFG_MAX_DZ   = 2'd0;
    localparam logic [1:0] CFG_MAX_DPHI = 2'd1;
    localparam logic [1:0] CFG_Z_PER_PS = 2'd2;

    localparam logic [11:0] MAX_DZ_RST   = 12'd200;
    localparam logic [15:0] MAX_DPHI_RST = 16'd2086;
    localparam logic [15:0] Z_PER_PS_RST = 16'd5090;

    localparam int CORDIC_W = 27;

    typedef struct packed {
        logic signed [9:0]  x;
        logic signed [9:0]  y;
        logic signed [11:0] z;
        logic [15:0]        angle;
    } t_hit;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_step;

    function automatic logic [15:0] atan_tab(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            4'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gnhm_cordic.sv
// ----------------------------------------------------------------------------
// gnhm_cordic
// Vectoring CORDIC, one micro-rotation per cycle, 16-bit binary angle out.
// ----------------------------------------------------------------------------
`default_nettype none

module gnhm_cordic (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic signed [9:0] i_x,
    input  wire logic signed [9:0] i_y,
    output logic                   o_done,
    output logic [15:0]            o_angle
);

    localparam int W = gnhm_pkg::CORDIC_W;

    logic signed [W-1:0] r_x, r_y;
    logic [15:0]         r_acc;
    logic [3:0]          r_iter;
    logic                r_busy, r_zero, r_done;

    logic signed [10:0]  s_x0, s_y0;
    logic signed [W-1:0] s_xs, s_ys;

    always_comb begin
        s_x0 = (i_x < 0) ? -11'(i_x) : 11'(i_x);
        s_y0 = (i_x < 0) ? -11'(i_y) : 11'(i_y);
        s_xs = r_x >>> r_iter;
        s_ys = r_y >>> r_iter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_zero <= (i_x == 0) && (i_y == 0);
                r_acc  <= (i_x < 0) ? 16'h8000 : 16'h0000;
                r_x    <= W'(s_x0) <<< 14;
                r_y    <= W'(s_y0) <<< 14;
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x   <= r_x + s_ys;
                    r_y   <= r_y - s_xs;
                    r_acc <= r_acc + gnhm_pkg::atan_tab(r_iter);
                end else begin
                    r_x   <= r_x - s_ys;
                    r_y   <= r_y + s_xs;
                    r_acc <= r_acc - gnhm_pkg::atan_tab(r_iter);
                end
                r_iter <= r_iter + 4'd1;
                if (r_iter == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? 16'h0000 : r_acc;

endmodule

`default_nettype wire

FILE: rtl/gnhm_cell.sv
// ----------------------------------------------------------------------------
// gnhm_cell
// One stored hit; loads directly or takes its neighbour's hit on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module gnhm_cell (
    input  wire logic           i_clk,
    input  wire logic           i_wr,
    input  wire gnhm_pkg::t_hit i_wr_hit,
    input  wire logic           i_shift,
    input  wire gnhm_pkg::t_hit i_nb_hit,
    output gnhm_pkg::t_hit      o_hit
);

    gnhm_pkg::t_hit r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_hit <= i_wr_hit;
        end else if (i_shift) begin
            r_hit <= i_nb_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

FILE: rtl/gnhm_eval.sv
// ----------------------------------------------------------------------------
// gnhm_eval
// Two-stage gate and distance unit, keeps the best qualifying hit.
// ----------------------------------------------------------------------------
`default_nettype none

module gnhm_eval #(
    parameter int IDX_W = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gnhm_pkg::t_step    i_step,
    input  wire logic [IDX_W-1:0]   i_idx,
    input  wire gnhm_pkg::t_hit     i_hit,
    input  wire gnhm_pkg::t_hit     i_point,
    input  wire logic [11:0]        i_max_dz,
    input  wire logic [15:0]        i_max_dphi,
    output logic                    o_found,
    output logic [IDX_W-1:0]        o_idx,
    output logic [24:0]             o_dist
);

    logic signed [10:0] s_dx, s_dy;
    logic signed [12:0] s_dz, s_dz_mag;
    logic [15:0]        s_dphi;
    logic signed [16:0] s_dphi_s, s_dphi_mag;
    logic signed [21:0] s_sqx, s_sqy;
    logic signed [25:0] s_sqz;
    logic               s_qual;
    logic [24:0]        s_sum;

    logic               r_v1;
    logic [IDX_W-1:0]   r_idx1;
    logic [20:0]        r_sqx, r_sqy;
    logic [23:0]        r_sqz;
    logic               r_found;
    logic [IDX_W-1:0]   r_idx;
    logic [24:0]        r_dist;

    always_comb begin
        s_dx       = 11'(i_point.x) - 11'(i_hit.x);
        s_dy       = 11'(i_point.y) - 11'(i_hit.y);
        s_dz       = 13'(i_point.z) - 13'(i_hit.z);
        s_dz_mag   = (s_dz < 0) ? -s_dz : s_dz;
        s_dphi     = i_point.angle - i_hit.angle;
        s_dphi_s   = {s_dphi[15], s_dphi};
        s_dphi_mag = (s_dphi_s < 0) ? -s_dphi_s : s_dphi_s;
        s_qual     = (s_dphi_mag <= $signed({1'b0, i_max_dphi}))
                     && (s_dz_mag <= $signed({1'b0, i_max_dz}));
        s_sqx      = s_dx * s_dx;
        s_sqy      = s_dy * s_dy;
        s_sqz      = s_dz * s_dz;
        s_sum      = 25'(r_sqx) + 25'(r_sqy) + 25'(r_sqz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_v1 <= i_step.valid && s_qual;
            if (i_step.clear) begin
                r_found <= 1'b0;
            end else if (r_v1 && (!r_found || s_sum <= r_dist)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_sqx  <= s_sqx[20:0];
        r_sqy  <= s_sqy[20:0];
        r_sqz  <= s_sqz[23:0];
        if (!i_step.clear && r_v1 && (!r_found || s_sum <= r_dist)) begin
            r_idx  <= r_idx1;
            r_dist <= s_sum;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_dist  = r_dist;

endmodule

`default_nettype wire

FILE: rtl/gated_nearest_hit_matcher_unit.sv
// ----------------------------------------------------------------------------
// gated_nearest_hit_matcher_unit
// Stores bar hits in a ring of cells and returns the nearest gated hit.
//
// channel   dir  fields (low bit up)
// s_axis    in   tuser: operation[1:0]; tdata: bar_x, bar_y, bar_dt, point_x,
//                point_y, point_z
// m_axis    out  tuser: matched; tdata: hit_index[5:0], distance_sq_mm2[29:6]
// cfg       in   we, idx, wdata[15:0]
//
// Clear and ignored items finish in the idle state; a load runs the CORDIC and
// then writes its cell. A query runs the CORDIC, then the ring rotates one hit
// per cycle past the gate unit, and then the gate unit's pipeline drains.
// Reset empties the store and loads the register defaults; no clearing pass.
// A new item is taken while a result waits; a query ends stalled until the
// output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_nearest_hit_matcher_unit #(
    parameter int MAX_HITS = gnhm_pkg::MAX_HITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // bar_x[9:0] bar_y[19:10] bar_dt[35:20] point_x[45:36] point_y[55:46]
    // point_z[67:56], zero pad
    input  wire logic [71:0] i_s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // hit_index[5:0] distance_sq_mm2[29:6], zero pad
    output logic [31:0]      o_m_axis_tdata,
    // matched
    output logic             o_m_axis_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CNT_W = $clog2(MAX_HITS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CORD, S_SCAN, S_DRAIN, S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_is_load, r_wait;
    logic [CNT_W-1:0]      r_count, r_step;
    logic [11:0]           r_max_dz;
    logic [15:0]           r_max_dphi, r_zpp;
    logic signed [32:0]    r_prod;
    gnhm_pkg::t_hit        r_item;
    logic                  r_out_valid, r_out_match;
    logic [5:0]            r_out_idx;
    logic [23:0]           r_out_dist;

    logic                  s_acc, s_start, s_wr, s_shift;
    logic signed [9:0]     s_x, s_y;
    logic signed [32:0]    s_zr;
    logic signed [11:0]    s_z;
    gnhm_pkg::t_hit        s_wr_hit;
    gnhm_pkg::t_hit        s_cell [MAX_HITS];
    gnhm_pkg::t_step       s_step;
    logic                  c_done;
    logic [15:0]           c_angle;
    logic                  e_found;
    logic [IDX_W-1:0]      e_idx;
    logic [24:0]           e_dist;
    logic [31:0]           s_idx32;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign s_x     = (i_s_axis_tuser == gnhm_pkg::OP_LOAD) ? i_s_axis_tdata[9:0]
                                                           : i_s_axis_tdata[45:36];
    assign s_y     = (i_s_axis_tuser == gnhm_pkg::OP_LOAD) ? i_s_axis_tdata[19:10]
                                                           : i_s_axis_tdata[55:46];
    assign s_start = s_acc && ((i_s_axis_tuser == gnhm_pkg::OP_QUERY)
                     || ((i_s_axis_tuser == gnhm_pkg::OP_LOAD)
                         && (r_count < CNT_W'(MAX_HITS))));

    always_comb begin
        s_zr = (r_prod + 33'sd32768) >>> 16;
        if (s_zr > 33'sd2047) begin
            s_z = 12'sd2047;
        end else if (s_zr < -33'sd2048) begin
            s_z = -12'sd2048;
        end else begin
            s_z = s_zr[11:0];
        end
        s_wr_hit       = r_item;
        s_wr_hit.z     = s_z;
        s_wr_hit.angle = c_angle;
        s_wr           = (r_state == S_CORD) && c_done && r_is_load;
        s_shift        = (r_state == S_SCAN);
        s_step.clear   = (r_state == S_CORD);
        s_step.valid   = (r_state == S_SCAN) && (r_step < r_count);
        s_idx32        = 32'(e_idx);
    end

    gnhm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_x     (s_x),
        .i_y     (s_y),
        .o_done  (c_done),
        .o_angle (c_angle)
    );

    for (genvar g = 0; g < MAX_HITS; g++) begin : g_cell
        gnhm_cell u_cell (
            .i_clk    (i_clk),
            .i_wr     (s_wr && (r_count == CNT_W'(g))),
            .i_wr_hit (s_wr_hit),
            .i_shift  (s_shift),
            .i_nb_hit (s_cell[(g + 1) % MAX_HITS]),
            .o_hit    (s_cell[g])
        );
    end

    gnhm_eval #(.IDX_W(IDX_W)) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s_step),
        .i_idx      (r_step[IDX_W-1:0]),
        .i_hit      (s_cell[0]),
        .i_point    (r_item),
        .i_max_dz   (r_max_dz),
        .i_max_dphi (r_max_dphi),
        .o_found    (e_found),
        .o_idx      (e_idx),
        .o_dist     (e_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_dz    <= gnhm_pkg::MAX_DZ_RST;
            r_max_dphi  <= gnhm_pkg::MAX_DPHI_RST;
            r_zpp       <= gnhm_pkg::Z_PER_PS_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gnhm_pkg::CFG_MAX_DZ:   r_max_dz   <= i_cfg_wdata[11:0];
                    gnhm_pkg::CFG_MAX_DPHI: r_max_dphi <= i_cfg_wdata;
                    gnhm_pkg::CFG_Z_PER_PS: r_zpp      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc && (i_s_axis_tuser == gnhm_pkg::OP_CLEAR)) begin
                        r_count <= '0;
                    end
                    if (s_start) begin
                        r_is_load <= (i_s_axis_tuser == gnhm_pkg::OP_LOAD);
                        r_state   <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (c_done) begin
                        if (r_is_load) begin
                            r_count <= r_count + CNT_W'(1);
                            r_state <= S_IDLE;
                        end else begin
                            r_step  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == CNT_W'(MAX_HITS - 1)) begin
                        r_wait  <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_wait <= 1'b1;
                    if (r_wait) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_match <= e_found;
                        r_out_idx   <= e_found ? s_idx32[5:0] : 6'd0;
                        r_out_dist  <= !e_found ? 24'd0
                                     : (e_dist > 25'h0FFFFFF) ? 24'hFFFFFF : e_dist[23:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_start) begin
            r_item.x     <= s_x;
            r_item.y     <= s_y;
            r_item.z     <= i_s_axis_tdata[67:56];
            r_item.angle <= c_angle;
            r_prod       <= $signed({17'd0, r_zpp}) * $signed(i_s_axis_tdata[35:20]);
        end else if ((r_state == S_CORD) && c_done && !r_is_load) begin
            r_item.angle <= c_angle;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_match;
    assign o_m_axis_tdata  = {2'b00, r_out_dist, r_out_idx};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_HITS))
        else $error("hit count beyond store depth");
    a_done_in_cord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == S_CORD))
        else $error("cordic finished outside its state");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step < CNT_W'(MAX_HITS)))
        else $error("scan step beyond ring length");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_axis_tready) |=> (r_state == S_DONE))
        else $error("result dropped while output busy");
`endif

endmodule

`default_nettype wire
